// File: rtl/tdr_pkg.sv
// Shared types, constants and the control program of the thermostat duty regulator.
`timescale 1ns / 1ps
package tdr_pkg;

    localparam int CYCLE_SECONDS = 180;
    localparam int STEP_HIGH     = 30;
    localparam int STEP_MID      = 15;
    localparam int COUNT_MAX     = 255;
    localparam int AVG_MAX       = 16383;

    localparam int TEMP_W  = 11;
    localparam int SEC_W   = 16;
    localparam int AVG_W   = 14;
    localparam int TOTAL_W = 22;
    localparam int COUNT_W = 8;
    localparam int GOAL_W  = 12;
    localparam int MINSW_W = 8;
    localparam int DIVR_W  = 8;
    localparam int DIVC_W  = 5;
    localparam int CFG_W   = 12;

    // The seconds count divided by the cycle length is the product with a rounded-up
    // reciprocal, shifted right; exact for every 16-bit count at this cycle length.
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 24;
    localparam logic [RECIP_W-1:0] CYCLE_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(CYCLE_SECONDS) - 64'd1) / 64'(CYCLE_SECONDS));

    localparam logic [DIVC_W-1:0] DIV_STEPS = DIVC_W'(TOTAL_W);
    localparam logic [DIVR_W-1:0] POS_THIRD = DIVR_W'(CYCLE_SECONDS / 3);
    localparam logic [DIVR_W-1:0] POS_TWO_THIRDS = DIVR_W'(2 * CYCLE_SECONDS / 3);

    typedef enum logic [0:0] {
        CFG_GOAL  = 1'b0,
        CFG_MINSW = 1'b1
    } cfg_index_t;

    typedef logic [3:0] step_t;

    localparam step_t STEP_FETCH      = 4'd0;
    localparam step_t STEP_CYCLE_QUOT = 4'd1;
    localparam step_t STEP_POS        = 4'd2;
    localparam step_t STEP_LOAD_AVG   = 4'd3;
    localparam step_t STEP_RUN_AVG    = 4'd4;
    localparam step_t STEP_SET_AVG    = 4'd5;
    localparam step_t STEP_ACCUM      = 4'd6;
    localparam step_t STEP_REG        = 4'd7;
    localparam step_t STEP_RETURN     = 4'd8;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_FETCH,
        OP_CYCLE_QUOT,
        OP_ITER,
        OP_STORE_POS,
        OP_LOAD_AVG,
        OP_SET_AVG,
        OP_ACCUM,
        OP_REGULATE
    } dp_op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_DIV_BUSY,
        COND_SKIP_DIV,
        COND_OUT_BLOCKED
    } cond_t;

    typedef struct packed {
        dp_op_t op;
        cond_t  cond;
        step_t  target;
    } ctrl_word_t;

    typedef struct packed {
        logic load;
        logic iter;
    } div_ctrl_t;

    function automatic ctrl_word_t rom_word(input step_t pc);
        ctrl_word_t w;
        begin
            unique case (pc)
                STEP_FETCH:      w = '{OP_FETCH,      COND_NO_INPUT,    STEP_FETCH};
                STEP_CYCLE_QUOT: w = '{OP_CYCLE_QUOT, COND_NEVER,       STEP_FETCH};
                STEP_POS:        w = '{OP_STORE_POS,  COND_SKIP_DIV,    STEP_ACCUM};
                STEP_LOAD_AVG:   w = '{OP_LOAD_AVG,   COND_NEVER,       STEP_FETCH};
                STEP_RUN_AVG:    w = '{OP_ITER,       COND_DIV_BUSY,    STEP_RUN_AVG};
                STEP_SET_AVG:    w = '{OP_SET_AVG,    COND_ALWAYS,      STEP_REG};
                STEP_ACCUM:      w = '{OP_ACCUM,      COND_NEVER,       STEP_FETCH};
                STEP_REG:        w = '{OP_REGULATE,   COND_OUT_BLOCKED, STEP_REG};
                STEP_RETURN:     w = '{OP_NOP,        COND_ALWAYS,      STEP_FETCH};
                default:         w = '{OP_NOP,        COND_ALWAYS,      STEP_FETCH};
            endcase
            return w;
        end
    endfunction

endpackage

// File: rtl/tdr_channels.sv
// Handshake channel interfaces for samples and results.
`timescale 1ns / 1ps
interface tdr_sample_if;
    import tdr_pkg::*;
    logic              valid;
    logic              ready;
    logic [TEMP_W-1:0] temp_sample;
    logic [SEC_W-1:0]  second_count;

    modport source (output valid, output temp_sample, output second_count, input ready);
    modport sink (input valid, input temp_sample, input second_count, output ready);
endinterface

interface tdr_result_if;
    import tdr_pkg::*;
    logic             valid;
    logic             ready;
    logic             relay_on;
    logic             demand_on;
    logic [AVG_W-1:0] average_temp;

    modport source (output valid, output relay_on, output demand_on, output average_temp,
                    input ready);
    modport sink (input valid, input relay_on, input demand_on, input average_temp,
                  output ready);
endinterface

// File: rtl/tdr_divider.sv
// Restoring serial divider that produces one quotient bit per iteration.
`timescale 1ns / 1ps
module tdr_divider
    import tdr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  div_ctrl_t          ctrl,
    input  logic [TOTAL_W-1:0] dividend,
    input  logic [DIVR_W-1:0]  divisor,
    output logic [TOTAL_W-1:0] quotient,
    output logic               last
);

    logic [TOTAL_W-1:0] quo_reg;
    logic [TOTAL_W-1:0] quo_next;
    logic [DIVR_W-1:0]  rem_reg;
    logic [DIVR_W-1:0]  rem_next;
    logic [DIVR_W-1:0]  dvs_reg;
    logic [DIVC_W-1:0]  count_reg;
    logic [DIVC_W-1:0]  count_next;
    logic [DIVR_W:0]    shifted;
    logic               fits;
    logic [DIVR_W:0]    diff;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[TOTAL_W-1]};
        fits    = shifted >= {1'b0, dvs_reg};
        diff    = shifted - {1'b0, dvs_reg};
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        if (ctrl.load)
        begin
            quo_next   = dividend;
            rem_next   = '0;
            count_next = DIV_STEPS;
        end
        else if (ctrl.iter)
        begin
            quo_next   = {quo_reg[TOTAL_W-2:0], fits};
            rem_next   = fits ? diff[DIVR_W-1:0] : shifted[DIVR_W-1:0];
            count_next = count_reg - DIVC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (ctrl.load)
        begin
            dvs_reg <= divisor;
        end
    end

    assign quotient  = quo_reg;
    assign last      = count_reg == DIVC_W'(1);

endmodule

// File: rtl/thermostat_duty_regulator.sv
// Top level of the averaging thermostat with duty-cycle relay drive.
`timescale 1ns / 1ps
// Each accepted sample (one per second) is handled by a small control program.
// The seconds count is reduced modulo the cycle length by a reciprocal
// multiplication over two steps, and on a cycle boundary a serial divider divides
// the sample sum by the count. An ordinary sample passes through the fetch,
// quotient, position, accumulate, regulate and return steps; a sample on a cycle
// boundary takes instead of the accumulate step the divider load, its 22
// iterations and the store of the new average; a stalled result holds the
// regulate step while it waits. The block takes one sample at a time.
// Configuration writes take effect at once and are meant for idle periods.
module thermostat_duty_regulator
    import tdr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    tdr_sample_if.sink        sample_in,
    tdr_result_if.source      result_out,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    step_t                pc_reg;
    step_t                pc_next;
    ctrl_word_t           cw;
    logic                 jump;
    div_ctrl_t            div_ctrl;
    logic [TOTAL_W-1:0]   div_dividend;
    logic [DIVR_W-1:0]    div_divisor;
    logic [TOTAL_W-1:0]   div_quotient;
    logic                 div_last;

    logic [GOAL_W-1:0]    goal_reg;
    logic [MINSW_W-1:0]   minsw_reg;
    logic [TOTAL_W-1:0]   total_reg;
    logic [COUNT_W-1:0]   number_reg;
    logic [AVG_W-1:0]     avg_hold_reg;
    logic                 relay_reg;
    logic [SEC_W-1:0]     last_change_reg;
    logic [AVG_W-1:0]     sample_reg;
    logic [SEC_W-1:0]     sec_reg;
    logic [SEC_W-1:0]     quot_reg;
    logic [DIVR_W-1:0]    pos_reg;
    logic                 out_valid_reg;
    logic                 out_relay_reg;
    logic                 out_demand_reg;
    logic [AVG_W-1:0]     out_avg_reg;

    logic                 accept;
    logic                 out_blocked;
    logic                 out_write;
    logic [SEC_W+RECIP_W-1:0] cycle_product;
    logic [SEC_W-1:0]     cycle_base;
    logic [SEC_W-1:0]     pos_full;
    logic [AVG_W:0]       scaled;
    logic [AVG_W-1:0]     sample_sat;
    logic [AVG_W-1:0]     goal_ext;
    logic                 demand;
    logic [SEC_W-1:0]     elapsed;
    logic                 do_switch;

    assign cw          = rom_word(pc_reg);
    assign accept      = (cw.op == OP_FETCH) && sample_in.valid;
    assign out_blocked = out_valid_reg && !result_out.ready;
    assign out_write   = (cw.op == OP_REGULATE) && !out_blocked;

    assign cycle_product = {{RECIP_W{1'b0}}, sec_reg} * {{SEC_W{1'b0}}, CYCLE_RECIP};
    assign cycle_base    = quot_reg * SEC_W'(CYCLE_SECONDS);
    assign pos_full      = sec_reg - cycle_base;

    always_comb
    begin
        unique case (cw.cond)
            COND_NEVER:       jump = 1'b0;
            COND_ALWAYS:      jump = 1'b1;
            COND_NO_INPUT:    jump = !sample_in.valid;
            COND_DIV_BUSY:    jump = !div_last;
            COND_SKIP_DIV:    jump = (number_reg == '0) || (pos_full != '0);
            COND_OUT_BLOCKED: jump = out_blocked;
            default:          jump = 1'b1;
        endcase
        pc_next = jump ? cw.target : pc_reg + step_t'(1);
    end

    always_comb
    begin
        div_ctrl.load = cw.op == OP_LOAD_AVG;
        div_ctrl.iter = cw.op == OP_ITER;
    end

    assign div_dividend = total_reg;
    assign div_divisor  = number_reg;

    tdr_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quotient),
        .last      (div_last)
    );

    always_comb
    begin
        scaled = {1'b0, sample_in.temp_sample, 3'b000}
               + {3'b000, sample_in.temp_sample, 1'b0};
        sample_sat = scaled[AVG_W] ? AVG_W'(AVG_MAX) : scaled[AVG_W-1:0];
        goal_ext   = {{(AVG_W-GOAL_W){1'b0}}, goal_reg};
        if (avg_hold_reg > goal_ext + AVG_W'(STEP_HIGH))
        begin
            demand = 1'b1;
        end
        else if (avg_hold_reg > goal_ext + AVG_W'(STEP_MID))
        begin
            demand = pos_reg < POS_TWO_THIRDS;
        end
        else if (avg_hold_reg > goal_ext)
        begin
            demand = pos_reg < POS_THIRD;
        end
        else
        begin
            demand = 1'b0;
        end
        elapsed   = sec_reg - last_change_reg;
        do_switch = (elapsed >= {{(SEC_W-MINSW_W){1'b0}}, minsw_reg}) && (demand != relay_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg          <= STEP_FETCH;
            goal_reg        <= GOAL_W'(1750);
            minsw_reg       <= MINSW_W'(10);
            total_reg       <= '0;
            number_reg      <= '0;
            avg_hold_reg    <= AVG_W'(2000);
            relay_reg       <= 1'b1;
            last_change_reg <= SEC_W'(65526);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_GOAL:  goal_reg  <= cfg_wdata[GOAL_W-1:0];
                    CFG_MINSW: minsw_reg <= cfg_wdata[MINSW_W-1:0];
                    default:   goal_reg  <= goal_reg;
                endcase
            end
            if (cw.op == OP_SET_AVG)
            begin
                avg_hold_reg <= div_quotient[AVG_W-1:0];
                total_reg    <= {{(TOTAL_W-AVG_W){1'b0}}, sample_reg};
                number_reg   <= COUNT_W'(1);
            end
            else if (cw.op == OP_ACCUM)
            begin
                if (number_reg == '0)
                begin
                    avg_hold_reg <= sample_reg;
                    total_reg    <= {{(TOTAL_W-AVG_W){1'b0}}, sample_reg};
                    number_reg   <= COUNT_W'(1);
                end
                else if (number_reg < COUNT_W'(COUNT_MAX))
                begin
                    total_reg  <= total_reg + {{(TOTAL_W-AVG_W){1'b0}}, sample_reg};
                    number_reg <= number_reg + COUNT_W'(1);
                end
            end
            if (out_write && do_switch)
            begin
                relay_reg       <= demand;
                last_change_reg <= sec_reg;
            end
            if (out_write)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample_sat;
            sec_reg    <= sample_in.second_count;
        end
        if (cw.op == OP_CYCLE_QUOT)
        begin
            quot_reg <= cycle_product[SEC_W+RECIP_SHIFT-1:RECIP_SHIFT];
        end
        if (cw.op == OP_STORE_POS)
        begin
            pos_reg <= pos_full[DIVR_W-1:0];
        end
        if (out_write)
        begin
            out_relay_reg  <= do_switch ? demand : relay_reg;
            out_demand_reg <= demand;
            out_avg_reg    <= avg_hold_reg;
        end
    end

    assign sample_in.ready         = cw.op == OP_FETCH;
    assign result_out.valid        = out_valid_reg;
    assign result_out.relay_on     = out_relay_reg;
    assign result_out.demand_on    = out_demand_reg;
    assign result_out.average_temp = out_avg_reg;

`ifndef SYNTHESIS
    // Once seeded, the sample count never returns to the unseeded value.
    a_seed_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (number_reg != '0) |=> (number_reg != '0))
        else $error("sample count lost its seed");

    // A sample transfer is followed by a busy sequence, never an immediate second one.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_in.valid && sample_in.ready) |=> !sample_in.ready)
        else $error("sample taken while the previous one is still in work");

    // The relay only changes together with a result being produced.
    a_relay_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        (relay_reg != $past(relay_reg)) |-> $past(out_write))
        else $error("relay changed without a result");
`endif

endmodule

// File: tb/tdr_reading_checker.sv
// Checker that predicts every thermostat reading from the accepted samples and compares it.
`timescale 1ns / 1ps
module tdr_reading_checker
    import tdr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    tdr_sample_if            samples,
    tdr_result_if            readings,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    output int               fail_count,
    output int               in_flight
);

    typedef struct packed {
        logic             relay_on;
        logic             demand_on;
        logic [AVG_W-1:0] average_temp;
    } reading_t;

    logic [GOAL_W-1:0]  goal;
    logic [MINSW_W-1:0] min_gap;
    logic [TOTAL_W-1:0] run_total;
    logic [COUNT_W-1:0] run_count;
    logic [AVG_W-1:0]   avg_now;
    logic               relay_now;
    logic [SEC_W-1:0]   relay_moved_sec;
    reading_t           due_readings[$];
    int                 mismatches = 0;
    int                 open_count = 0;

    assign fail_count = mismatches;
    assign in_flight  = open_count;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatches < 100)
        begin
            $display("%0t tdr_reading_checker: %s: got %0d, expected %0d",
                     $time, what, got, want);
        end
        mismatches++;
    endtask

    function automatic reading_t regulate(input logic [TEMP_W-1:0] temp,
                                          input logic [SEC_W-1:0] sec);
        int unsigned      scaled;
        int unsigned      pos;
        int unsigned      avg;
        int unsigned      target;
        logic             want;
        logic [SEC_W-1:0] elapsed;
        reading_t         r;
        scaled = 32'(temp) * 10;
        if (scaled > AVG_MAX)
        begin
            scaled = AVG_MAX;
        end
        pos = 32'(sec) % CYCLE_SECONDS;
        if (run_count == '0)
        begin
            avg_now   = AVG_W'(scaled);
            run_total = TOTAL_W'(scaled);
            run_count = COUNT_W'(1);
        end
        else if (pos == 0)
        begin
            avg_now   = AVG_W'(run_total / run_count);
            run_total = TOTAL_W'(scaled);
            run_count = COUNT_W'(1);
        end
        else if (run_count < COUNT_MAX)
        begin
            run_total = TOTAL_W'(32'(run_total) + scaled);
            run_count = run_count + 1'b1;
        end
        avg    = 32'(avg_now);
        target = 32'(goal);
        if (avg > target + STEP_HIGH)
        begin
            want = 1'b1;
        end
        else if (avg > target + STEP_MID)
        begin
            want = (pos < 2 * CYCLE_SECONDS / 3);
        end
        else if (avg > target)
        begin
            want = (pos < CYCLE_SECONDS / 3);
        end
        else
        begin
            want = 1'b0;
        end
        elapsed = sec - relay_moved_sec;
        if (elapsed >= SEC_W'(min_gap) && want != relay_now)
        begin
            relay_now       = want;
            relay_moved_sec = sec;
        end
        r.relay_on     = relay_now;
        r.demand_on    = want;
        r.average_temp = avg_now;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        reading_t due;
        if (!rst_n)
        begin
            goal            = GOAL_W'(1750);
            min_gap         = MINSW_W'(10);
            run_total       = '0;
            run_count       = '0;
            avg_now         = AVG_W'(2000);
            relay_now       = 1'b1;
            relay_moved_sec = SEC_W'(65526);
            due_readings.delete();
            open_count      = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_GOAL:  goal    = cfg_wdata[GOAL_W-1:0];
                    CFG_MINSW: min_gap = cfg_wdata[MINSW_W-1:0];
                    default:   ;
                endcase
            end
            if (samples.valid && samples.ready)
            begin
                due_readings.push_back(regulate(samples.temp_sample, samples.second_count));
            end
            if (readings.valid && readings.ready)
            begin
                if (due_readings.size() == 0)
                begin
                    report_mismatch("reading with nothing expected", 16'(readings.average_temp),
                                    16'd0);
                end
                else
                begin
                    due = due_readings.pop_front();
                    if (readings.relay_on !== due.relay_on)
                    begin
                        report_mismatch("relay_on", 16'(readings.relay_on), 16'(due.relay_on));
                    end
                    if (readings.demand_on !== due.demand_on)
                    begin
                        report_mismatch("demand_on", 16'(readings.demand_on),
                                        16'(due.demand_on));
                    end
                    if (readings.average_temp !== due.average_temp)
                    begin
                        report_mismatch("average_temp", 16'(readings.average_temp),
                                        16'(due.average_temp));
                    end
                end
            end
            open_count = due_readings.size();
        end
    end

endmodule

// File: tb/thermostat_duty_regulator_tb.sv
// Stimulus, clock, reset and final verdict for the thermostat duty regulator.
`timescale 1ns / 1ps
module thermostat_duty_regulator_tb;
    import tdr_pkg::*;

    localparam int LIMIT_CYCLES   = 1_000_000;
    localparam int PHASES         = 8;
    localparam int BURST_ITEMS    = 100;
    localparam int FULL_RUN_ITEMS = 270;
    localparam int DRAIN_CYCLES   = 64;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [0:0]        cfg_index;
    logic [CFG_W-1:0]  cfg_wdata;
    int                fail_count;
    int                in_flight;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                cycles = 0;
    logic [SEC_W-1:0]  sec_now;
    logic [GOAL_W-1:0] goal_set;
    logic [MINSW_W-1:0] gap_set;

    tdr_sample_if sample_ch();
    tdr_result_if result_ch();

    thermostat_duty_regulator u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_ch),
        .result_out (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    tdr_reading_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (sample_ch),
        .readings   (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .in_flight  (in_flight)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("thermostat_duty_regulator_tb: done, errors");
            $finish;
        end
    end

    task automatic send_sample(input logic [TEMP_W-1:0] temp, input logic [SEC_W-1:0] sec);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.temp_sample  <= temp;
        sample_ch.second_count <= sec;
        @(posedge clk);
        while (!sample_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (in_flight != 0);
        @(posedge clk);
    endtask

    task automatic configure(input logic [GOAL_W-1:0] goal, input logic [CFG_W-1:0] gap_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GOAL;
        cfg_wdata <= CFG_W'(goal);
        @(posedge clk);
        cfg_index <= CFG_MINSW;
        cfg_wdata <= gap_word;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly a running seconds count with temperatures close to the goal, so that
    // the average walks through every band; a few transfers are pure noise.
    task automatic random_burst(input int n);
        int pick;
        int temp_i;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                send_sample(TEMP_W'($urandom_range(2047)), SEC_W'($urandom));
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 50)
                begin
                    sec_now = sec_now + 1'b1;
                end
                else if (pick < 80)
                begin
                    sec_now = sec_now + SEC_W'($urandom_range(60, 2));
                end
                else
                begin
                    sec_now = sec_now - SEC_W'(32'(sec_now) % CYCLE_SECONDS)
                              + SEC_W'(CYCLE_SECONDS);
                end
                temp_i = int'(goal_set) / 10 + int'($urandom_range(12)) - 6;
                if (temp_i < 0)
                begin
                    temp_i = 0;
                end
                send_sample(TEMP_W'(temp_i), sec_now);
            end
        end
    endtask

    // A long stretch inside one cycle drives the sample count into saturation.
    task automatic hold_run(input int n);
        sec_now = SEC_W'(CYCLE_SECONDS + 7);
        for (int i = 0; i < n; i++)
        begin
            send_sample(TEMP_W'($urandom_range(2047)), sec_now);
        end
        sec_now = SEC_W'(2 * CYCLE_SECONDS);
        send_sample(TEMP_W'($urandom_range(2047)), sec_now);
    endtask

    initial
    begin
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= CFG_GOAL;
        cfg_wdata              <= '0;
        sample_ch.valid        <= 1'b0;
        sample_ch.temp_sample  <= '0;
        sample_ch.second_count <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first sample lands on a cycle boundary and saturates when scaled.
        goal_set = GOAL_W'(1750);
        send_sample(11'd2047, 16'd0);
        send_sample(11'd1638, 16'd1);
        send_sample(11'd1639, 16'd2);
        send_sample(11'd0, 16'd180);
        send_sample(11'd0, 16'd360);
        send_sample(11'd178, 16'd540);
        send_sample(11'd179, 16'd720);
        send_sample(11'd177, 16'd900);
        send_sample(11'd177, 16'd959);
        send_sample(11'd176, 16'd1080);
        send_sample(11'd176, 16'd1199);
        send_sample(11'd176, 16'd1200);
        send_sample(11'd175, 16'd1260);
        send_sample(11'd175, 16'd1319);
        send_sample(11'd175, 16'd1320);
        send_sample(11'd176, 16'd1440);
        send_sample(11'd177, 16'd1500);
        send_sample(11'd175, 16'd1620);
        // The seconds count wraps between these transfers.
        send_sample(11'd175, 16'd65520);
        send_sample(11'd200, 16'd65535);
        send_sample(11'd200, 16'd0);
        send_sample(11'd0, 16'd5);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    goal_set = GOAL_W'(800);
                    gap_set  = MINSW_W'(0);
                end
                1:
                begin
                    goal_set = GOAL_W'(2290);
                    gap_set  = MINSW_W'(255);
                end
                2:
                begin
                    goal_set = GOAL_W'(0);
                    gap_set  = MINSW_W'(255);
                end
                3:
                begin
                    goal_set = GOAL_W'(4095);
                    gap_set  = MINSW_W'(0);
                end
                default:
                begin
                    goal_set = GOAL_W'($urandom_range(2290, 800));
                    gap_set  = MINSW_W'($urandom_range(255));
                end
            endcase
            configure(goal_set, {4'($urandom_range(15)), gap_set});
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 57;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 57;
                end
                default:
                begin
                    send_idle_pct  = 36;
                    recv_stall_pct = 36;
                end
            endcase
            sec_now = SEC_W'($urandom);
            random_burst(BURST_ITEMS);
            if (phase == 4)
            begin
                hold_run(FULL_RUN_ITEMS);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("thermostat_duty_regulator_tb: done, clean");
        end
        else
        begin
            $display("thermostat_duty_regulator_tb: done, errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/tdr_pkg.sv
rtl/tdr_channels.sv
rtl/tdr_divider.sv
rtl/thermostat_duty_regulator.sv
tb/tdr_reading_checker.sv
tb/thermostat_duty_regulator_tb.sv
